[design/wsse_pkg.sv]
`default_nettype none
package wsse_pkg;

   localparam int MAX_IMAGES_DEF = 256;
   localparam int POSITIONS_DEF  = 16384;
   localparam int WORD_BITS_DEF  = 64;

   localparam logic [2:0] CMD_WRITE_BIT = 3'd0;
   localparam logic [2:0] CMD_SET_AVG   = 3'd1;
   localparam logic [2:0] CMD_CLEAR     = 3'd2;
   localparam logic [2:0] CMD_AVG_TERM  = 3'd3;
   localparam logic [2:0] CMD_COEF      = 3'd4;
   localparam logic [2:0] CMD_READ      = 3'd5;

   localparam logic [1:0] COLOR_NONE = 2'd3;

   typedef enum logic [2:0] {
      OP_BIT, OP_AVG, OP_CLR, OP_DIST, OP_COEF, OP_READ
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         image;
      logic [1:0]         color;
      logic               negative;
      logic [13:0]        position;
      logic               bit_value;
      logic signed [23:0] average_value;
      logic [23:0]        weight;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_BASE, ST_ADDR, ST_RD, ST_WAIT, ST_MUL, ST_WR,
      ST_RSP_RD, ST_RSP
   } state_type;

endpackage
`default_nettype wire

[design/wsse_ram.sv]
`default_nettype none
module wsse_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[design/wsse_front.sv]
`default_nettype none
module wsse_front #(
   parameter int MaxImages = wsse_pkg::MAX_IMAGES_DEF,
   parameter int Positions = wsse_pkg::POSITIONS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         command,
   input  wire logic [7:0]         image,
   input  wire logic [1:0]         color,
   input  wire logic               negative,
   input  wire logic [13:0]        position,
   input  wire logic               bit_value,
   input  wire logic signed [23:0] average_value,
   input  wire logic [23:0]        weight,
   input  wire logic               accept_en,
   output logic                    head_valid,
   output wsse_pkg::entry_type     head,
   input  wire logic               head_pop
);
   import wsse_pkg::*;

   localparam int Depth = 4;
   localparam int PW = 2;

   entry_type       fifo_ff [Depth];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            keep, color_ok, img_ok, pos_ok, accept, wr, rd;
   op_type          op;
   entry_type       item;

   // classify: drop beats that have no effect
   always_comb begin
      color_ok = color != COLOR_NONE;
      img_ok   = 32'(image) < MaxImages;
      pos_ok   = 32'(position) < Positions;
      keep     = 1'b0;
      op       = OP_BIT;
      case (command)
         CMD_WRITE_BIT: begin
            keep = color_ok && img_ok && pos_ok;
            op   = OP_BIT;
         end
         CMD_SET_AVG: begin
            keep = color_ok && img_ok;
            op   = OP_AVG;
         end
         CMD_CLEAR: begin
            keep = 1'b1;
            op   = OP_CLR;
         end
         CMD_AVG_TERM: begin
            keep = color_ok;
            op   = OP_DIST;
         end
         CMD_COEF: begin
            keep = color_ok && pos_ok;
            op   = OP_COEF;
         end
         CMD_READ: begin
            keep = 1'b1;
            op   = OP_READ;
         end
         default: begin
            keep = 1'b0;
            op   = OP_BIT;
         end
      endcase
      item = '{op: op, image: image, color: color, negative: negative,
               position: position, bit_value: bit_value,
               average_value: average_value, weight: weight};
   end

   assign full       = (count_ff == (PW+1)'(Depth)) || !accept_en;
   assign accept     = push && !full;
   assign wr         = accept && keep;
   assign head_valid = count_ff != '0;
   assign rd         = head_pop && head_valid;
   assign head       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(wr) - (PW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

[design/wsse_back.sv]
`default_nettype none
module wsse_back #(
   parameter int MaxImages = wsse_pkg::MAX_IMAGES_DEF,
   parameter int Positions = wsse_pkg::POSITIONS_DEF,
   parameter int WordBits  = wsse_pkg::WORD_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [8:0]     active_images,
   input  wire logic           head_valid,
   input  wire wsse_pkg::entry_type head,
   output logic                head_pop,
   output logic                ready,
   output logic                empty,
   input  wire logic           pop,
   output logic [7:0]          score_image,
   output logic signed [47:0]  score
);
   import wsse_pkg::*;

   localparam int Words    = (MaxImages + WordBits - 1) / WordBits;
   localparam int IB       = $clog2(MaxImages);
   localparam int CB       = $clog2(MaxImages + 1);
   localparam int WB       = $clog2(WordBits);
   localparam int WDB      = (Words > 1) ? $clog2(Words) : 1;
   localparam int Rows     = 6 * Positions;
   localparam int RW       = $clog2(Rows);
   localparam int SigDepth = Rows * Words;
   localparam int SAW      = $clog2(SigDepth);
   localparam int AvgDepth = 3 * MaxImages;
   localparam int AAW      = $clog2(AvgDepth);
   localparam logic signed [49:0] SatMax = 50'sd140737488355327;
   localparam logic signed [49:0] SatMin = -50'sd140737488355328;

   state_type          state_ff, state_in;
   entry_type          cur_ff;
   logic [RW-1:0]      row_ff;
   logic [SAW-1:0]     base_ff;
   logic [WDB-1:0]     word_ff, quot;
   logic [WB-1:0]      bit_ff, rem;
   logic [IB-1:0]      idx_ff;
   logic [CB-1:0]      n_ff, n_in;
   logic               init_ff, hit_ff, last, img_ok;
   logic [16:0]        mag_ff;
   logic [47:0]        term_ff;
   logic               out_valid_ff;
   logic [7:0]         out_image_ff;
   logic [47:0]        out_score_ff;

   logic               sig_rd, sig_we, avg_rd, avg_we, sc_rd, sc_we;
   logic [SAW-1:0]     sig_addr;
   logic [WordBits-1:0] sig_q, sig_wdata;
   logic [AAW-1:0]     avg_rd_addr, avg_wr_addr;
   logic [23:0]        avg_q;
   logic [IB-1:0]      sc_rd_addr;
   logic [47:0]        sc_q, sc_wdata;
   logic signed [24:0] diff;
   logic [24:0]        absd;
   logic signed [49:0] sum;

   assign last   = (32'(idx_ff) + 32'd1) == 32'(n_ff);
   assign img_ok = 32'(cur_ff.image) < MaxImages;
   assign n_in   = (32'(active_images) > MaxImages) ? CB'(MaxImages) : CB'(active_images);

   // word and bit of an image index
   always_comb begin
      quot = '0;
      for (int k = 1; k < Words; k++) begin
         if (32'(cur_ff.image) >= k * WordBits) begin
            quot = WDB'(k);
         end
      end
      rem = WB'(32'(cur_ff.image) - 32'(quot) * WordBits);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:    if (32'(idx_ff) == MaxImages - 1) state_in = ST_IDLE;
         ST_IDLE:   if (head_valid) state_in = ST_BASE;
         ST_BASE: begin
            case (cur_ff.op)
               OP_AVG:  state_in = ST_IDLE;
               OP_CLR:  state_in = ST_CLR;
               OP_READ: state_in = ST_RSP_RD;
               default: state_in = ST_ADDR;
            endcase
         end
         ST_ADDR: begin
            if (cur_ff.op == OP_BIT) begin
               state_in = ST_RD;
            end else if (n_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD:     state_in = ST_WAIT;
         ST_WAIT:   state_in = (cur_ff.op == OP_BIT) ? ST_IDLE : ST_MUL;
         ST_MUL:    state_in = ST_WR;
         ST_WR:     state_in = last ? ST_IDLE : ST_RD;
         ST_RSP_RD: if (!out_valid_ff) state_in = ST_RSP;
         ST_RSP:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_pop    = (state_ff == ST_IDLE) && head_valid;
      sig_rd      = state_ff == ST_RD;
      sig_we      = (state_ff == ST_WAIT) && (cur_ff.op == OP_BIT);
      sig_addr    = base_ff + SAW'(word_ff);
      sig_wdata   = sig_q;
      sig_wdata[bit_ff] = cur_ff.bit_value;
      avg_rd      = state_ff == ST_RD;
      avg_rd_addr = AAW'(AAW'(cur_ff.color) * AAW'(MaxImages)) + AAW'(idx_ff);
      avg_we      = (state_ff == ST_BASE) && (cur_ff.op == OP_AVG);
      avg_wr_addr = AAW'(AAW'(cur_ff.color) * AAW'(MaxImages)) + AAW'(cur_ff.image);
      sc_rd       = (state_ff == ST_RD) || ((state_ff == ST_RSP_RD) && !out_valid_ff);
      sc_rd_addr  = (state_ff == ST_RSP_RD) ? IB'(cur_ff.image) : idx_ff;
      sc_we       = (state_ff == ST_CLR) || (state_ff == ST_WR);
      // saturating update
      if (cur_ff.op == OP_DIST) begin
         sum = $signed({{2{sc_q[47]}}, sc_q}) + $signed({2'b00, term_ff});
      end else begin
         sum = $signed({{2{sc_q[47]}}, sc_q}) - $signed({2'b00, term_ff});
      end
      if (state_ff == ST_CLR) begin
         sc_wdata = '0;
      end else if (sum > SatMax) begin
         sc_wdata = SatMax[47:0];
      end else if (sum < SatMin) begin
         sc_wdata = SatMin[47:0];
      end else begin
         sc_wdata = sum[47:0];
      end
      diff = $signed({cur_ff.average_value[23], cur_ff.average_value})
             - $signed({avg_q[23], avg_q});
      absd = diff[24] ? 25'(-diff) : 25'(diff);
   end

   wsse_ram #(.Width(WordBits), .Depth(SigDepth)) u_sig (
      .clock(clock), .wr_en(sig_we), .wr_addr(sig_addr), .wr_data(sig_wdata),
      .rd_en(sig_rd), .rd_addr(sig_addr), .rd_data(sig_q)
   );

   wsse_ram #(.Width(24), .Depth(AvgDepth)) u_avg (
      .clock(clock), .wr_en(avg_we), .wr_addr(avg_wr_addr),
      .wr_data(cur_ff.average_value), .rd_en(avg_rd), .rd_addr(avg_rd_addr),
      .rd_data(avg_q)
   );

   wsse_ram #(.Width(48), .Depth(MaxImages)) u_score (
      .clock(clock), .wr_en(sc_we), .wr_addr(idx_ff), .wr_data(sc_wdata),
      .rd_en(sc_rd), .rd_addr(sc_rd_addr), .rd_data(sc_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         init_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (32'(idx_ff) == MaxImages - 1) begin
                  init_ff <= 1'b1;
               end
            end
            ST_BASE: idx_ff <= '0;
            ST_WR:   idx_ff <= idx_ff + 1'b1;
            ST_RSP:  out_valid_ff <= 1'b1;
            default: idx_ff <= idx_ff;
         endcase
      end
      case (state_ff)
         ST_IDLE: if (head_valid) cur_ff <= head;
         ST_BASE: begin
            row_ff <= RW'((32'(cur_ff.color) * 2 + 32'(cur_ff.negative)) * Positions
                          + 32'(cur_ff.position));
            n_ff   <= n_in;
         end
         ST_ADDR: begin
            base_ff <= SAW'(32'(row_ff) * Words);
            word_ff <= (cur_ff.op == OP_BIT) ? quot : '0;
            bit_ff  <= (cur_ff.op == OP_BIT) ? rem : '0;
         end
         ST_WAIT: begin
            mag_ff <= absd[24:8];
            hit_ff <= sig_q[bit_ff];
         end
         ST_MUL: begin
            if (cur_ff.op == OP_DIST) begin
               term_ff <= 48'(mag_ff) * 48'(cur_ff.weight);
            end else begin
               term_ff <= hit_ff ? 48'(cur_ff.weight) : '0;
            end
         end
         ST_WR: begin
            if (32'(bit_ff) == WordBits - 1) begin
               bit_ff  <= '0;
               word_ff <= word_ff + 1'b1;
            end else begin
               bit_ff <= bit_ff + 1'b1;
            end
         end
         ST_RSP: begin
            out_image_ff <= cur_ff.image;
            out_score_ff <= img_ok ? sc_q : '0;
         end
         default: begin
            mag_ff <= mag_ff;
         end
      endcase
   end

   assign ready       = init_ff;
   assign empty       = !out_valid_ff;
   assign score_image = out_image_ff;
   assign score       = $signed(out_score_ff);

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RSP |-> !out_valid_ff) else $error("result overwritten");
   a_sig_we: assert property (@(posedge clock) disable iff (reset)
      sig_we |-> $past(state_ff) == ST_RD) else $error("signature write without read");
   a_loop_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && last) |=> state_ff == ST_IDLE) else $error("loop overrun");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> state_ff == ST_IDLE) else $error("dequeue while busy");
endmodule
`default_nettype wire

[design/wavelet_signature_score_engine.sv]
// A bit write reads a signature word and writes it back, an average write stores
// a table entry, a clear zeroes all scores, a read copies one score to a result,
// average and coefficient terms walk the active images (one read, wait, multiply
// and write-back of the score memory per image). One item is handled at a time;
// a four-beat queue decouples input. Reset: synchronous; then a clearing pass
// zeroes scores, with full held high until it ends. The active count resets to 256.
`default_nettype none
module wavelet_signature_score_engine #(
   parameter int MaxImages = wsse_pkg::MAX_IMAGES_DEF,
   parameter int Positions = wsse_pkg::POSITIONS_DEF,
   parameter int WordBits  = wsse_pkg::WORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_command,
   input  wire logic [7:0]         req_image,
   input  wire logic [1:0]         req_color,
   input  wire logic               req_negative,
   input  wire logic [13:0]        req_position,
   input  wire logic               req_bit_value,
   input  wire logic signed [23:0] req_average_value,
   input  wire logic [23:0]        req_weight,
   output logic                    empty,
   input  wire logic               pop,
   output logic [7:0]              rsp_score_image,
   output logic signed [47:0]      rsp_score,
   input  wire logic               csr_we,
   input  wire logic [8:0]         csr_wdata
);
   import wsse_pkg::*;

   logic [8:0] active_ff;
   logic       head_valid, head_pop, ready;
   entry_type  head;

   // hold the active image count; the user must write it only while idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 9'd256;
      end else if (csr_we) begin
         active_ff <= csr_wdata;
      end
   end

   // front: accept and classify beats, drop no-ops
   wsse_front #(.MaxImages(MaxImages), .Positions(Positions)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .command(req_command), .image(req_image), .color(req_color),
      .negative(req_negative), .position(req_position),
      .bit_value(req_bit_value), .average_value(req_average_value),
      .weight(req_weight), .accept_en(ready),
      .head_valid(head_valid), .head(head), .head_pop(head_pop)
   );

   // back: walk the tables, update scores and answer reads, advance one image per pass
   wsse_back #(.MaxImages(MaxImages), .Positions(Positions), .WordBits(WordBits)) u_back (
      .clock(clock), .reset(reset), .active_images(active_ff),
      .head_valid(head_valid), .head(head), .head_pop(head_pop), .ready(ready),
      .empty(empty), .pop(pop), .score_image(rsp_score_image), .score(rsp_score)
   );
endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
   import wsse_pkg::*;

   localparam int NIMG = 256;
   // colours 1 and 2 and planes other than 0 are loaded only this far
   localparam int NARROW = 16;
   localparam longint SCORE_TOP = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SCORE_BOT = -SCORE_TOP - 1;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]         cmd;
      logic [7:0]         image;
      logic [1:0]         color;
      logic               negative;
      logic [13:0]        position;
      logic               bit_value;
      logic signed [23:0] average_value;
      logic [23:0]        weight;
   } query_beat_type;

   typedef struct {
      logic [7:0]  image;
      logic [47:0] score;
   } score_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [2:0]         req_command = '0;
   logic [7:0]         req_image = '0;
   logic [1:0]         req_color = '0;
   logic               req_negative = 1'b0;
   logic [13:0]        req_position = '0;
   logic               req_bit_value = 1'b0;
   logic signed [23:0] req_average_value = '0;
   logic [23:0]        req_weight = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [7:0]         rsp_score_image;
   logic signed [47:0] rsp_score;
   logic               csr_we = 1'b0;
   logic [8:0]         csr_wdata = '0;

   // Predictor state: own copy of the tables and the active count
   logic [NIMG-1:0]    sig_rows [int];
   logic signed [23:0] avg_mem [3][NIMG];
   longint             score_mem [NIMG];
   logic [8:0]         active_cfg;

   // Coefficient rows that the random part may query: one per plane
   logic [13:0]        probe_pos [6];
   logic [NIMG-1:0]    probe_written [6];

   score_beat_type     pending_scores [$];
   int                 failures = 0;
   bit                 hold_rsp = 1'b0;
   bit                 calm = 1'b0;

   always #5 clock = ~clock;

   wavelet_signature_score_engine uut (
      .clock, .reset, .push, .full,
      .req_command, .req_image, .req_color, .req_negative, .req_position,
      .req_bit_value, .req_average_value, .req_weight,
      .empty, .pop, .rsp_score_image, .rsp_score,
      .csr_we, .csr_wdata
   );

   function automatic int eff_active();
      return (active_cfg > NIMG) ? NIMG : int'(active_cfg);
   endfunction

   function automatic longint clip48(longint v);
      if (v > SCORE_TOP) return SCORE_TOP;
      if (v < SCORE_BOT) return SCORE_BOT;
      return v;
   endfunction

   // Advance the predictor by one accepted beat
   task automatic predict_scores(input query_beat_type q);
      int key;
      longint diff;
      longint mag;
      score_beat_type sb;
      key = (int'(q.color) * 2 + int'(q.negative)) * 16384 + int'(q.position);
      case (q.cmd)
         CMD_WRITE_BIT: if (q.color != COLOR_NONE) begin
            if (!sig_rows.exists(key)) sig_rows[key] = '0;
            sig_rows[key][q.image] = q.bit_value;
         end
         CMD_SET_AVG: if (q.color != COLOR_NONE) avg_mem[q.color][q.image] = q.average_value;
         CMD_CLEAR: foreach (score_mem[i]) score_mem[i] = 0;
         CMD_AVG_TERM: if (q.color != COLOR_NONE) begin
            for (int i = 0; i < eff_active(); i++) begin
               diff = longint'(q.average_value) - longint'(avg_mem[q.color][i]);
               mag = (diff < 0 ? -diff : diff) >>> 8;
               score_mem[i] = clip48(score_mem[i] + mag * longint'(q.weight));
            end
         end
         CMD_COEF: if (q.color != COLOR_NONE) begin
            for (int i = 0; i < eff_active(); i++)
               if (sig_rows.exists(key) && sig_rows[key][i])
                  score_mem[i] = clip48(score_mem[i] - longint'(q.weight));
         end
         CMD_READ: begin
            sb.image = q.image;
            sb.score = score_mem[q.image][47:0];
            pending_scores.push_back(sb);
         end
         default: ;
      endcase
   endtask

   // Send one beat: optional idle gap, then hold push until accepted
   task automatic send_query(input query_beat_type q);
      if (!calm && $urandom_range(99) < 7) begin
         push = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      push = 1'b1;
      req_command = q.cmd;
      req_image = q.image;
      req_color = q.color;
      req_negative = q.negative;
      req_position = q.position;
      req_bit_value = q.bit_value;
      req_average_value = q.average_value;
      req_weight = q.weight;
      do @(posedge clock); while (full);
      predict_scores(q);
      if (q.cmd == CMD_WRITE_BIT && q.color != COLOR_NONE)
         for (int p = 0; p < 6; p++)
            if (probe_pos[p] == q.position && p == int'(q.color) * 2 + int'(q.negative))
               probe_written[p][q.image] = 1'b1;
      @(negedge clock);
   endtask

   function automatic query_beat_type blank_query(input logic [2:0] cmd);
      query_beat_type q;
      q.cmd = cmd;
      q.image = 8'($urandom);
      q.color = 2'($urandom_range(2));
      q.negative = 1'($urandom);
      q.position = 14'($urandom);
      q.bit_value = 1'($urandom);
      q.average_value = 24'($urandom);
      q.weight = 24'($urandom);
      return q;
   endfunction

   task automatic send_simple(input logic [2:0] cmd, input logic [7:0] img,
                              input logic [1:0] col, input logic [23:0] wt);
      query_beat_type q;
      q = blank_query(cmd);
      q.image = img;
      q.color = col;
      q.weight = wt;
      send_query(q);
   endtask

   task automatic send_coef(input int p, input logic [23:0] wt);
      query_beat_type q;
      q = blank_query(CMD_COEF);
      q.color = 2'(p / 2);
      q.negative = 1'(p % 2);
      q.position = probe_pos[p];
      q.weight = wt;
      send_query(q);
   endtask

   // Drain and let the engine finish any silent work
   task automatic settle();
      push = 1'b0;
      while (pending_scores.size() != 0) @(negedge clock);
      repeat (5 * (4 * eff_active() + 20) + 300) @(negedge clock);
   endtask

   task automatic set_active(input logic [8:0] n);
      settle();
      csr_we = 1'b1;
      csr_wdata = n;
      @(negedge clock);
      csr_we = 1'b0;
      active_cfg = n;
   endtask

   // Write every not yet written bit of the probe rows below the active count;
   // planes other than 0 only up to NARROW images
   task automatic fill_probe_rows();
      query_beat_type q;
      for (int p = 0; p < 6; p++)
         for (int i = 0; i < eff_active(); i++)
            if (!probe_written[p][i] && (p == 0 || i < NARROW)) begin
               q = blank_query(CMD_WRITE_BIT);
               q.image = 8'(i);
               q.color = 2'(p / 2);
               q.negative = 1'(p % 2);
               q.position = probe_pos[p];
               send_query(q);
            end
   endtask

   // Colour 0 for every image, colours 1 and 2 for the first NARROW images
   task automatic test_load_averages();
      query_beat_type q;
      for (int c = 0; c < 3; c++)
         for (int i = 0; i < (c == 0 ? NIMG : NARROW); i++) begin
            q = blank_query(CMD_SET_AVG);
            q.image = 8'(i);
            q.color = 2'(c);
            if (i == 0) q.average_value = 24'sh800000;
            if (i == 1) q.average_value = 24'sh7FFFFF;
            send_query(q);
         end
   endtask

   task automatic test_directed();
      query_beat_type q;
      set_active(9'd4);
      fill_probe_rows();
      send_simple(CMD_CLEAR, 8'd0, 2'd0, 24'd0);
      send_simple(CMD_READ, 8'd0, 2'd0, 24'd0);
      send_simple(CMD_READ, 8'd255, 2'd0, 24'd0);
      q = blank_query(CMD_AVG_TERM);
      q.average_value = 24'sh7FFFFF;
      q.weight = 24'hFFFFFF;
      send_query(q);
      q.average_value = 24'sh800000;
      q.weight = 24'd0;
      send_query(q);
      for (int p = 0; p < 6; p++) send_coef(p, p == 0 ? 24'hFFFFFF : 24'd1);
      send_simple(CMD_READ, 8'd0, 2'd0, 24'd0);
      send_simple(CMD_READ, 8'd3, 2'd0, 24'd0);
      // spare commands and colour three do nothing
      send_simple(CMD_SPARE6, 8'd1, 2'd0, 24'hFFFFFF);
      send_simple(CMD_SPARE7, 8'd1, 2'd0, 24'hFFFFFF);
      send_simple(CMD_AVG_TERM, 8'd0, COLOR_NONE, 24'hFFFFFF);
      send_simple(CMD_COEF, 8'd0, COLOR_NONE, 24'hFFFFFF);
      send_simple(CMD_SET_AVG, 8'd2, COLOR_NONE, 24'd0);
      send_simple(CMD_WRITE_BIT, 8'd2, COLOR_NONE, 24'd0);
      send_simple(CMD_READ, 8'd1, 2'd0, 24'd0);
      send_simple(CMD_READ, 8'd2, 2'd0, 24'd0);
   endtask

   // Drive image 0 up against the top of the score range
   task automatic test_saturation();
      query_beat_type q;
      send_simple(CMD_CLEAR, 8'd0, 2'd0, 24'd0);
      for (int k = 0; k < 132; k++) begin
         q = blank_query(CMD_AVG_TERM);
         q.color = 2'd0;
         q.average_value = 24'sh7FFFFF;
         q.weight = 24'hFFFFFF;
         send_query(q);
      end
      send_simple(CMD_READ, 8'd0, 2'd0, 24'd0);
      send_coef(0, 24'hFFFFFF);
      send_simple(CMD_READ, 8'd0, 2'd0, 24'd0);
   endtask

   // Stall the result side so the queue fills and full rises
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 24; k++) send_simple(CMD_READ, 8'($urandom), 2'd0, 24'd0);
      join
   endtask

   task automatic test_random(input logic [8:0] act, input int count);
      query_beat_type q;
      int r;
      bit wide;
      set_active(act);
      fill_probe_rows();
      // above NARROW images only colour 0 and plane 0 are fully loaded
      wide = eff_active() > NARROW;
      for (int k = 0; k < count; k++) begin
         calm = (k >= count / 3 && k < count / 2);
         r = $urandom_range(99);
         if (r < 18) begin
            q = blank_query(CMD_WRITE_BIT);
            q.color = 2'($urandom_range(3));
            if ($urandom_range(9) < 7) begin
               r = $urandom_range(5);
               q.color = 2'(r / 2);
               q.negative = 1'(r % 2);
               q.position = probe_pos[r];
            end
            send_query(q);
         end else if (r < 28) begin
            q = blank_query(CMD_SET_AVG);
            q.color = 2'($urandom_range(3));
            send_query(q);
         end else if (r < 31) begin
            send_query(blank_query(CMD_CLEAR));
         end else if (r < 50) begin
            q = blank_query(CMD_AVG_TERM);
            q.color = 2'($urandom_range(3));
            if (wide && q.color != COLOR_NONE) q.color = 2'd0;
            if ($urandom_range(3) == 0) q.weight = 24'hFFFFFF;
            send_query(q);
         end else if (r < 72) begin
            if ($urandom_range(9) == 0) send_simple(CMD_COEF, 8'd0, COLOR_NONE, 24'($urandom));
            else send_coef(wide ? 0 : int'($urandom_range(5)), 24'($urandom));
         end else if (r < 95) begin
            send_query(blank_query(CMD_READ));
         end else begin
            send_query(blank_query($urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7));
         end
      end
      calm = 1'b0;
   endtask

   // Result side: random pops, long holds on request
   always @(negedge clock)
      pop <= !hold_rsp && (calm || $urandom_range(99) >= 7);

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      score_beat_type sb;
      if (!reset && pop && !empty) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected result image %0d score %h", $time,
                     rsp_score_image, rsp_score);
            failures++;
         end else begin
            sb = pending_scores.pop_front();
            if (rsp_score_image !== sb.image) begin
               $display("%0t: score_image expected %0d actual %0d", $time, sb.image,
                        rsp_score_image);
               failures++;
            end
            if (rsp_score !== sb.score) begin
               $display("%0t: score expected %h actual %h", $time, sb.score, rsp_score);
               failures++;
            end
         end
      end
   end

   initial begin
      foreach (score_mem[i]) score_mem[i] = 0;
      active_cfg = 9'd256;
      probe_pos[0] = 14'd0;
      probe_pos[1] = 14'd16383;
      for (int p = 2; p < 6; p++) probe_pos[p] = 14'($urandom);
      foreach (probe_written[p]) probe_written[p] = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_load_averages();
      test_directed();
      test_saturation();
      test_backpressure();
      test_random(9'd1, 120);
      test_random(9'd0, 20);
      test_random(9'd256, 40);
      test_random(9'd9, 120);
      test_random(9'd511, 20);
      test_random(9'($urandom_range(2, 40)), 100);
      test_random(9'd3, 60);
      settle();
      if (failures == 0) $display("wavelet_signature_score_engine regression: pass");
      else $display("wavelet_signature_score_engine regression: fail");
      $finish;
   end

   initial begin
      #40ms;
      $display("wavelet_signature_score_engine regression: fail");
      $finish;
   end

endmodule

[sim.f]
design/wsse_pkg.sv
design/wsse_ram.sv
design/wsse_front.sv
design/wsse_back.sv
design/wavelet_signature_score_engine.sv
verif/tb.sv
